@@ src/fplc_pkg.sv @@
// Shared constants, types and command/status structures of the Fenwick level counter.
`default_nettype none
package fplc_pkg;

	localparam int COORD_SPAN = 32768;
	localparam int MAX_POINTS = 16384;

	localparam int COORD_W = 15;
	localparam int BIN_W = 14;
	localparam int LEVEL_W = 14;
	localparam int COUNT_W = 15;

	localparam int TREE_AW = $clog2(COORD_SPAN);
	localparam int HIST_AW = $clog2(MAX_POINTS);
	localparam int IDX_W = TREE_AW + 1;
	localparam int TOTAL_W = $clog2(MAX_POINTS) + 1;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	typedef struct packed {
		logic load;
		logic q_step;
		logic u_start;
		logic u_step;
		logic hist_rd;
		logic hist_wr;
		logic clr_step;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic q_last;
		logic u_last;
		logic clr_last;
		logic is_full;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

@@ src/fplc_req_if.sv @@
// Request channel carrying insert and read words into the level counter.
`default_nettype none
interface fplc_req_if import fplc_pkg::*; ();
	logic               valid;
	logic               ready;
	op_t                operation;
	logic [COORD_W-1:0] coordinate;
	logic [BIN_W-1:0]   bin_index;

	modport source(output valid, output operation, output coordinate, output bin_index,
		input ready);
	modport sink(input valid, input operation, input coordinate, input bin_index,
		output ready);
endinterface
`default_nettype wire

@@ src/fplc_rsp_if.sv @@
// Response channel carrying one result word per request.
`default_nettype none
interface fplc_rsp_if import fplc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] level;
	logic [COUNT_W-1:0] bin_count;
	logic               full_res;

	modport source(output valid, output level, output bin_count, output full_res,
		input ready);
	modport sink(input valid, input level, input bin_count, input full_res,
		output ready);
endinterface
`default_nettype wire

@@ src/fenwick_prefix_level_counter.sv @@
// Top level of the Fenwick level counter: controller, datapath and checks.
// After reset the block sweeps both memories to zero, one entry of each per cycle; req.ready
// stays low until that pass ends. Requests are then handled one at a time. A read passes
// from acceptance through S_BRD, which reads the histogram, to S_FIN, which registers the
// response word. An insert of coordinate x runs the query walk, S_QDRAIN, S_HRD, S_HWR, the
// update walk, S_UDRAIN and S_FIN; an insert into a full block goes straight to S_FIN. The
// query walk visits popcount(x+1) tree nodes and the update walk U nodes from x+1 upward;
// popcount(x+1) + U never exceeds 17. Both walks use the single read port of the tree memory.
// Either kind of word waits in S_FIN while the previous word is still in the output register.
// A finished response word waits in an output register, and the next request is accepted
// while it waits.
`default_nettype none
module fenwick_prefix_level_counter import fplc_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	fplc_req_if.sink  req,
	fplc_rsp_if.source rsp
);
	cmd_t  cmd;
	stat_t stat;

	fplc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req.valid),
		.in_operation(req.operation),
		.stat        (stat),
		.in_ready    (req.ready),
		.cmd         (cmd)
	);

	fplc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_operation (req.operation),
		.in_coordinate(req.coordinate),
		.in_bin_index (req.bin_index),
		.out_ready    (rsp.ready),
		.stat         (stat),
		.out_valid    (rsp.valid),
		.out_level    (rsp.level),
		.out_bin_count(rsp.bin_count),
		.out_full_res (rsp.full_res)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !req.ready)
		else $error("request accepted while a word is still in work");

	a_fin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> rsp.valid)
		else $error("finished word did not reach the response register");

	a_mem_cmds: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.q_step, cmd.u_step, cmd.clr_step, cmd.hist_rd, cmd.hist_wr}))
		else $error("conflicting memory commands");

	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.full_res) |-> (rsp.level == '0 && rsp.bin_count == '0))
		else $error("rejected insert returned a nonzero level or count");
endmodule
`default_nettype wire

@@ src/fplc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fplc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ src/fplc_datapath.sv @@
// Datapath: tree and histogram memories, walk index, accumulator and result register.
`default_nettype none
module fplc_datapath import fplc_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	input  wire op_t                in_operation,
	input  wire logic [COORD_W-1:0] in_coordinate,
	input  wire logic [BIN_W-1:0]   in_bin_index,
	input  wire logic               out_ready,
	output      stat_t              stat,
	output      logic               out_valid,
	output      logic [LEVEL_W-1:0] out_level,
	output      logic [COUNT_W-1:0] out_bin_count,
	output      logic               out_full_res
);
	logic [IDX_W-1:0]   pos_q;
	logic [BIN_W-1:0]   bin_q;
	op_t                op_q;
	logic               full_q;
	logic [IDX_W-1:0]   idx_q;
	logic [LEVEL_W-1:0] acc_q;
	logic [TOTAL_W-1:0] total_q;
	logic               q_pend_s1;
	logic               u_pend_s1;
	logic [TREE_AW-1:0] u_addr_s1;
	logic               out_valid_q;
	logic [LEVEL_W-1:0] level_q;
	logic [COUNT_W-1:0] count_q;
	logic               full_res_q;

	logic [IDX_W-1:0]   low;
	logic [IDX_W:0]     u_sum;
	logic [COORD_W-1:0] coord_sat;
	logic [IDX_W-1:0]   pos_in;
	logic               is_full;

	logic               tree_we;
	logic [TREE_AW-1:0] tree_waddr;
	logic [TOTAL_W-1:0] tree_wdata;
	logic               tree_re;
	logic [TOTAL_W-1:0] tree_rdata;

	logic               hist_we;
	logic [HIST_AW-1:0] hist_waddr;
	logic [COUNT_W-1:0] hist_wdata;
	logic [HIST_AW-1:0] hist_raddr;
	logic [COUNT_W-1:0] hist_rdata;

	assign low = idx_q & (~idx_q + IDX_W'(1));
	assign u_sum = {1'b0, idx_q} + {1'b0, low};
	assign coord_sat = (IDX_W'(in_coordinate) >= IDX_W'(COORD_SPAN)) ?
		COORD_W'(COORD_SPAN - 1) : in_coordinate;
	assign pos_in = IDX_W'(coord_sat) + IDX_W'(1);
	assign is_full = (total_q == TOTAL_W'(MAX_POINTS));

	assign stat.q_last = (idx_q == low);
	assign stat.u_last = (u_sum > (IDX_W + 1)'(COORD_SPAN));
	assign stat.clr_last = (idx_q[TREE_AW-1:0] == {TREE_AW{1'b1}});
	assign stat.is_full = is_full;
	assign stat.out_free = !out_valid_q || out_ready;

	assign tree_re = cmd.q_step || cmd.u_step;
	assign tree_we = cmd.clr_step || u_pend_s1;
	assign tree_waddr = cmd.clr_step ? idx_q[TREE_AW-1:0] : u_addr_s1;
	assign tree_wdata = cmd.clr_step ? '0 : tree_rdata + TOTAL_W'(1);

	assign hist_raddr = (op_q == OP_READ) ? HIST_AW'(bin_q) : HIST_AW'(acc_q);
	assign hist_we = cmd.clr_step || cmd.hist_wr;
	assign hist_waddr = cmd.clr_step ? idx_q[HIST_AW-1:0] : HIST_AW'(acc_q);
	assign hist_wdata = cmd.clr_step ? '0 : hist_rdata + COUNT_W'(1);

	fplc_ram #(
		.WIDTH(TOTAL_W),
		.DEPTH(COORD_SPAN)
	) u_tree_ram (
		.clk  (clk),
		.we   (tree_we),
		.waddr(tree_waddr),
		.wdata(tree_wdata),
		.re   (tree_re),
		.raddr(idx_q[TREE_AW-1:0]),
		.rdata(tree_rdata)
	);

	fplc_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(MAX_POINTS)
	) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(hist_waddr),
		.wdata(hist_wdata),
		.re   (cmd.hist_rd),
		.raddr(hist_raddr),
		.rdata(hist_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q <= pos_in;
			bin_q <= in_bin_index;
			op_q <= in_operation;
			full_q <= (in_operation == OP_INSERT) && is_full;
		end
		u_addr_s1 <= idx_q[TREE_AW-1:0];
		if (cmd.load) begin
			acc_q <= '0;
		end else if (q_pend_s1) begin
			acc_q <= acc_q + LEVEL_W'(tree_rdata);
		end
		if (cmd.fin) begin
			level_q <= (op_q == OP_INSERT && !full_q) ? acc_q : '0;
			count_q <= (op_q == OP_READ) ? hist_rdata : '0;
			full_res_q <= full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			total_q <= '0;
			q_pend_s1 <= 1'b0;
			u_pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			q_pend_s1 <= cmd.q_step;
			u_pend_s1 <= cmd.u_step;
			priority if (cmd.load) begin
				idx_q <= pos_in;
			end else if (cmd.u_start) begin
				idx_q <= pos_q;
			end else if (cmd.q_step) begin
				idx_q <= idx_q - low;
			end else if (cmd.u_step) begin
				idx_q <= u_sum[IDX_W-1:0];
			end else if (cmd.clr_step) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.hist_wr) begin
				total_q <= total_q + TOTAL_W'(1);
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_level = level_q;
	assign out_bin_count = count_q;
	assign out_full_res = full_res_q;
endmodule
`default_nettype wire

@@ src/fplc_ctrl.sv @@
// Controller state machine sequencing the clearing pass, tree walks and histogram update.
`default_nettype none
module fplc_ctrl import fplc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire op_t   in_operation,
	input  wire stat_t stat,
	output      logic  in_ready,
	output      cmd_t  cmd
);
	typedef enum logic [9:0] {
		S_CLEAR  = 10'b00_0000_0001,
		S_IDLE   = 10'b00_0000_0010,
		S_QRY    = 10'b00_0000_0100,
		S_QDRAIN = 10'b00_0000_1000,
		S_HRD    = 10'b00_0001_0000,
		S_HWR    = 10'b00_0010_0000,
		S_UPD    = 10'b00_0100_0000,
		S_UDRAIN = 10'b00_1000_0000,
		S_BRD    = 10'b01_0000_0000,
		S_FIN    = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					priority if (in_operation == OP_READ) begin
						state_d = S_BRD;
					end else if (stat.is_full) begin
						state_d = S_FIN;
					end else begin
						state_d = S_QRY;
					end
				end
			end
			S_QRY: begin
				cmd.q_step = 1'b1;
				if (stat.q_last) begin
					state_d = S_QDRAIN;
				end
			end
			S_QDRAIN: begin
				cmd.u_start = 1'b1;
				state_d = S_HRD;
			end
			S_HRD: begin
				cmd.hist_rd = 1'b1;
				state_d = S_HWR;
			end
			S_HWR: begin
				cmd.hist_wr = 1'b1;
				state_d = S_UPD;
			end
			S_UPD: begin
				cmd.u_step = 1'b1;
				if (stat.u_last) begin
					state_d = S_UDRAIN;
				end
			end
			S_UDRAIN: begin
				state_d = S_FIN;
			end
			S_BRD: begin
				cmd.hist_rd = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire
